// File: rtl/kss_pkg.sv
`timescale 1ns / 1ps

package kss_pkg;

	typedef enum logic [1:0] {
		KSS_OP_PUSH  = 2'd0,
		KSS_OP_POP   = 2'd1,
		KSS_OP_WRITE = 2'd2,
		KSS_OP_READ  = 2'd3
	} kss_op_t;

	typedef enum logic [1:0] {
		KSS_ST_OK       = 2'd0,
		KSS_ST_OVERFLOW = 2'd1,
		KSS_ST_EMPTY    = 2'd2
	} kss_status_t;

	// word returned for an empty stack
	localparam logic [31:0] KSS_EMPTY_WORD = 32'hFFFF_FFFF;

	// strobes into the entry store
	typedef struct packed {
		logic link_rd;
		logic data_rd;
		logic link_wr;
		logic data_wr;
	} kss_mem_ctl_t;

endpackage

// File: rtl/kss_req_if.sv
`timescale 1ns / 1ps

interface kss_req_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  opcode;
	logic        [2:0]  stack_id;
	logic signed [31:0] value;

	modport source (output valid, output opcode, output stack_id, output value, input ready);
	modport sink   (input valid, input opcode, input stack_id, input value, output ready);
endinterface

// File: rtl/kss_rsp_if.sv
`timescale 1ns / 1ps

interface kss_rsp_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic signed [31:0] top_value;

	modport source (output valid, output status, output top_value, input ready);
	modport sink   (input valid, input status, input top_value, output ready);
endinterface

// File: rtl/k_stacks_shared_store.sv
`timescale 1ns / 1ps
// Several LIFO stacks sharing one entry store; free entries sit on a linked free list.
// Channel req (sink) carries one request: opcode, stack_id, value. Channel rsp (source)
// returns exactly one result per request: status and the addressed stack's top value
// after the operation (-1 when that stack is empty). Both use valid/ready; a transfer
// happens on a rising edge with valid and ready high.
// One request is in flight at a time; ready is high while the sequencer is idle.
// The result is registered (rsp.valid rises with it) as follows: push, overwrite and any
// request on an empty or out-of-range stack finish in S_EXEC; read top, and push on a full
// store with a non-empty stack, read the entry data and finish in S_DATA; pop reads the
// top entry's link in S_EXEC, unlinks it in S_POP2 and finishes there when the stack runs
// empty, else in S_DATA. The next request is taken the cycle after the result is
// registered. The steps follow the chain of registered reads: stack top, then the entry
// link, then the entry data.
// Reset (arst_n low, asynchronous) empties every stack and puts all entries on the free
// list at once; no clearing pass is needed and requests are taken right after reset.
// A stalled rsp holds its result; the next request is still accepted and worked, and
// its result waits in a holding register until rsp drains.
module k_stacks_shared_store #(
	parameter int ENTRIES    = 64,
	parameter int STACKS     = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	kss_req_if.sink   req,
	kss_rsp_if.source rsp
);

	localparam int AW = $clog2(ENTRIES);
	localparam int PW = $clog2(ENTRIES+1);
	localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
	localparam int XW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;
	localparam logic [PW-1:0] NULL_PTR = PW'(ENTRIES);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP2,
		S_DATA,
		S_RESP
	} state_t;

	function automatic logic [31:0] read_out(input logic [DATA_WIDTH-1:0] d);
		logic [XW-1:0] x;
		x = XW'($signed(d));
		return x[31:0];
	endfunction

	state_t state_q;

	// request fields
	kss_pkg::kss_op_t      op_q;
	logic [SW-1:0]         sidx_q;
	logic                  sid_ok_q;
	logic [DATA_WIDTH-1:0] val_q;

	// stack top store
	logic [PW-1:0] top_mem [STACKS];
	logic          top_vld_q [STACKS];
	logic [PW-1:0] top_rd_q;
	logic          top_hit_q;

	logic [PW-1:0] free_head_q;
	kss_pkg::kss_status_t pend_status_q;

	logic                 out_valid_q;
	kss_pkg::kss_status_t out_status_q;
	logic [31:0]          out_value_q;
	kss_pkg::kss_status_t hold_status_q;
	logic [31:0]          hold_value_q;

	// entry store ports
	kss_pkg::kss_mem_ctl_t ctl;
	logic [AW-1:0]         rd_addr;
	logic [AW-1:0]         wr_addr;
	logic [PW-1:0]         wr_link;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [PW-1:0]         rd_link;
	logic [DATA_WIDTH-1:0] rd_data;

	logic                  accept;
	logic                  slot_free;
	logic [SW-1:0]         sid_idx;
	logic                  sid_ok;
	logic [XW-1:0]         val_x;
	logic [PW-1:0]         t_c;
	logic                  t_ok;
	logic                  fh_ok;

	logic                  top_we;
	logic [PW-1:0]         top_wdata;
	logic                  fh_we;
	logic [PW-1:0]         fh_d;
	logic                  res_done;
	kss_pkg::kss_status_t  res_status;
	logic [31:0]           res_value;
	logic                  to_data;
	kss_pkg::kss_status_t  pend_d;
	state_t                state_d;

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign slot_free = !out_valid_q || rsp.ready;
	assign sid_idx   = SW'(req.stack_id);
	assign sid_ok    = (32'(req.stack_id) < STACKS);
	assign val_x     = XW'(req.value);

	assign t_c   = top_hit_q ? top_rd_q : NULL_PTR;
	assign t_ok  = (t_c < NULL_PTR);
	assign fh_ok = (free_head_q < NULL_PTR);

	kss_entry_store #(
		.ENTRIES    (ENTRIES),
		.DATA_WIDTH (DATA_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.rd_addr (rd_addr),
		.wr_addr (wr_addr),
		.wr_link (wr_link),
		.wr_data (wr_data),
		.rd_link (rd_link),
		.rd_data (rd_data)
	);

	always_comb begin
		ctl        = '0;
		rd_addr    = '0;
		wr_addr    = '0;
		wr_link    = '0;
		wr_data    = val_q;
		top_we     = 1'b0;
		top_wdata  = '0;
		fh_we      = 1'b0;
		fh_d       = free_head_q;
		res_done   = 1'b0;
		res_status = kss_pkg::KSS_ST_OK;
		res_value  = kss_pkg::KSS_EMPTY_WORD;
		to_data    = 1'b0;
		pend_d     = kss_pkg::KSS_ST_OK;
		state_d    = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					// fetch the free head's link in case this is a push
					ctl.link_rd = fh_ok;
					rd_addr     = free_head_q[AW-1:0];
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				if (!sid_ok_q) begin
					res_done   = 1'b1;
					res_status = kss_pkg::KSS_ST_EMPTY;
				end else begin
					unique case (op_q)
						kss_pkg::KSS_OP_PUSH: begin
							if (fh_ok) begin
								ctl.data_wr = 1'b1;
								ctl.link_wr = 1'b1;
								wr_addr     = free_head_q[AW-1:0];
								wr_link     = t_c;
								top_we      = 1'b1;
								top_wdata   = free_head_q;
								fh_we       = 1'b1;
								fh_d        = rd_link;
								res_done    = 1'b1;
								res_value   = read_out(val_q);
							end else if (t_ok) begin
								ctl.data_rd = 1'b1;
								rd_addr     = t_c[AW-1:0];
								to_data     = 1'b1;
								pend_d      = kss_pkg::KSS_ST_OVERFLOW;
							end else begin
								res_done   = 1'b1;
								res_status = kss_pkg::KSS_ST_OVERFLOW;
							end
						end
						kss_pkg::KSS_OP_POP: begin
							if (t_ok) begin
								ctl.link_rd = 1'b1;
								rd_addr     = t_c[AW-1:0];
								state_d     = S_POP2;
							end else begin
								res_done   = 1'b1;
								res_status = kss_pkg::KSS_ST_EMPTY;
							end
						end
						kss_pkg::KSS_OP_WRITE: begin
							res_done = 1'b1;
							if (t_ok) begin
								ctl.data_wr = 1'b1;
								wr_addr     = t_c[AW-1:0];
								res_value   = read_out(val_q);
							end else begin
								res_status = kss_pkg::KSS_ST_EMPTY;
							end
						end
						kss_pkg::KSS_OP_READ: begin
							if (t_ok) begin
								ctl.data_rd = 1'b1;
								rd_addr     = t_c[AW-1:0];
								to_data     = 1'b1;
							end else begin
								res_done   = 1'b1;
								res_status = kss_pkg::KSS_ST_EMPTY;
							end
						end
						default: begin
							res_done   = 1'b1;
							res_status = kss_pkg::KSS_ST_EMPTY;
						end
					endcase
				end
			end
			S_POP2: begin
				// unlink the old top and return it to the front of the free list
				top_we      = 1'b1;
				top_wdata   = rd_link;
				ctl.link_wr = 1'b1;
				wr_addr     = t_c[AW-1:0];
				wr_link     = free_head_q;
				fh_we       = 1'b1;
				fh_d        = t_c;
				if (rd_link < NULL_PTR) begin
					ctl.data_rd = 1'b1;
					rd_addr     = rd_link[AW-1:0];
					to_data     = 1'b1;
				end else begin
					res_done = 1'b1;
				end
			end
			S_DATA: begin
				res_done   = 1'b1;
				res_status = pend_status_q;
				res_value  = read_out(rd_data);
			end
			S_RESP: begin
				if (slot_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		if (to_data) begin
			state_d = S_DATA;
		end
		if (res_done) begin
			state_d = slot_free ? S_IDLE : S_RESP;
		end
	end

	// stack top store: data without reset, valid bits cleared by reset
	always_ff @(posedge clk) begin
		if (top_we) begin
			top_mem[sidx_q] <= top_wdata;
		end
		if (accept && sid_ok) begin
			top_rd_q <= top_mem[sid_idx];
		end
		if (accept) begin
			op_q   <= kss_pkg::kss_op_t'(req.opcode);
			sidx_q <= sid_idx;
			val_q  <= val_x[DATA_WIDTH-1:0];
		end
		if (res_done && !slot_free) begin
			hold_status_q <= res_status;
			hold_value_q  <= res_value;
		end
		if (to_data) begin
			pend_status_q <= pend_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sid_ok_q     <= 1'b0;
			top_hit_q    <= 1'b0;
			free_head_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= kss_pkg::KSS_ST_OK;
			out_value_q  <= '0;
			for (int i = 0; i < STACKS; i++) begin
				top_vld_q[i] <= 1'b0;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				sid_ok_q  <= sid_ok;
				top_hit_q <= sid_ok && top_vld_q[sid_idx];
			end
			if (top_we) begin
				top_vld_q[sidx_q] <= 1'b1;
			end
			if (fh_we) begin
				free_head_q <= fh_d;
			end
			if (res_done && slot_free) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status;
				out_value_q  <= res_value;
			end else if (state_q == S_RESP && slot_free) begin
				out_valid_q  <= 1'b1;
				out_status_q <= hold_status_q;
				out_value_q  <= hold_value_q;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.status    = out_status_q;
	assign rsp.top_value = out_value_q;

endmodule

// File: rtl/kss_entry_store.sv
`timescale 1ns / 1ps

module kss_entry_store #(
	parameter int ENTRIES    = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  kss_pkg::kss_mem_ctl_t            ctl,
	input  logic [$clog2(ENTRIES)-1:0]       rd_addr,
	input  logic [$clog2(ENTRIES)-1:0]       wr_addr,
	input  logic [$clog2(ENTRIES+1)-1:0]     wr_link,
	input  logic [DATA_WIDTH-1:0]            wr_data,
	output logic [$clog2(ENTRIES+1)-1:0]     rd_link,
	output logic [DATA_WIDTH-1:0]            rd_data
);

	localparam int PW = $clog2(ENTRIES+1);

	logic [DATA_WIDTH-1:0] data_mem [ENTRIES];
	logic [PW-1:0]         link_mem [ENTRIES];

	logic [PW-1:0] link_q;
	logic [PW-1:0] rd_next_q;
	logic          rd_fresh_q;
	// entries at and above fill_q were never linked and still chain to the next one
	logic [PW-1:0] fill_q;

	always_ff @(posedge clk) begin
		if (ctl.data_wr) begin
			data_mem[wr_addr] <= wr_data;
		end
		if (ctl.link_wr) begin
			link_mem[wr_addr] <= wr_link;
		end
		if (ctl.data_rd) begin
			rd_data <= data_mem[rd_addr];
		end
		if (ctl.link_rd) begin
			link_q    <= link_mem[rd_addr];
			rd_next_q <= PW'(rd_addr) + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			rd_fresh_q <= 1'b0;
		end else begin
			if (ctl.link_rd) begin
				rd_fresh_q <= (PW'(rd_addr) >= fill_q);
			end
			// fresh entries leave the free chain in address order
			if (ctl.link_wr && (PW'(wr_addr) == fill_q)) begin
				fill_q <= fill_q + PW'(1);
			end
		end
	end

	assign rd_link = rd_fresh_q ? rd_next_q : link_q;

endmodule
